FILE: design/sle_pkg.sv
package sle_pkg;

  // request kinds
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOCATE = 2'd2;
  localparam logic [1:0] REQ_SORT   = 2'd3;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic       ok;
    logic [7:0] found_position;
    logic [7:0] list_length;
  } sle_result_t;

endpackage

FILE: design/sle_intf.sv
interface sle_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output position, output value, input ready);
  modport sink   (input valid, input req_type, input position, input value, output ready);
endinterface

interface sle_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] found_position;
  logic [7:0] list_length;

  modport source (output valid, output ok, output found_position, output list_length,
                  input ready);
  modport sink   (input valid, input ok, input found_position, input list_length,
                  output ready);
endinterface

FILE: design/sequential_list_engine.sv
// Sequential list engine: an ordered list of signed 32-bit values held in a
// single-port-write, single-port-read RAM of DEPTH entries plus a length count.
// Request channel (req): req_type 0 insert at 1-based position, 1 delete all
// entries equal to value, 2 locate first position of value, 3 sort ascending.
// Response channel (rsp): one beat per request with ok, found_position and
// the list length after the request.
// Both channels move a beat when valid and ready are high at a rising edge.
// Requests are taken one at a time; req.ready is high while the sequencer idles.
// Each request walks the RAM, one entry read per cycle:
//   insert  : shifts entries from the tail down to position (not when appending or rejected)
//   delete  : walks the whole list, locate: stops at the first match (no walk on an empty list)
//   sort    : insertion sort, each key walked down past the larger entries before it.
// A finished response sits in an output register; the next request is
// accepted while it waits, and that request finishes once the slot frees.
// A stalled receiver only holds the response and the sequencer's end state.
// Reset (rst, synchronous) empties the list; no RAM clearing pass is run,
// since only entries below the length are ever read.
module sequential_list_engine #(
  parameter int DEPTH = 128
) (
  input logic       clk,
  input logic       rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                 slot_free;
  logic                 res_valid;
  sle_pkg::sle_result_t res;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [31:0]          mem_rdata;
  logic                 out_valid;
  sle_pkg::sle_result_t out_data;

  // Control sequencer: decodes the request and walks the RAM
  sle_seq #(.DEPTH(DEPTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_req_type (req.req_type),
    .in_position (req.position),
    .in_value    (req.value),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // List store; read data is registered and arrives in the cycle after the address
  sle_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_data.ok;
  assign rsp.found_position = out_data.found_position;
  assign rsp.list_length    = out_data.list_length;

endmodule

FILE: design/sle_mem.sv
module sle_mem #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] store [DEPTH];

  // one write port, one read port, registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

FILE: design/sle_seq.sv
module sle_seq #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_position,
  input  logic [31:0]         in_value,
  input  logic                slot_free,
  output logic                res_valid,
  output sle_pkg::sle_result_t res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [31:0]         mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [31:0]         mem_rdata
);

  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_SH   = 4'd1;
  localparam logic [3:0] S_INS_PUT  = 4'd2;
  localparam logic [3:0] S_DEL      = 4'd3;
  localparam logic [3:0] S_LOC      = 4'd4;
  localparam logic [3:0] S_SORT_T   = 4'd5;
  localparam logic [3:0] S_SORT_CMP = 4'd6;
  localparam logic [3:0] S_SORT_PUT = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] wr;
  logic [CW-1:0] k;
  logic [CW-1:0] m;
  logic [7:0]    pos;
  logic [31:0]   val;
  logic [31:0]   tval;
  logic          ok;
  logic [7:0]    found;

  logic          ins_ok;
  logic          ins_append;
  logic          differs;
  logic          greater;
  logic          more_items;
  logic          more_keys;
  logic [CW-1:0] wr_next;

  assign ins_ok     = (in_position != 8'd0)
                    && (PW'(in_position) <= PW'(count) + PW'(1))
                    && (count < CW'(DEPTH));
  assign ins_append = PW'(in_position) == PW'(count) + PW'(1);
  assign differs    = mem_rdata != val;
  assign greater    = $signed(mem_rdata) > $signed(tval);
  assign more_items = (idx + CW'(1)) < count;
  assign more_keys  = (k + CW'(1)) < count;
  assign wr_next    = wr + CW'(differs);

  assign in_ready  = state == S_IDLE;
  assign res_valid = (state == S_DONE) && slot_free;
  assign res.ok             = ok;
  assign res.found_position = found;
  assign res.list_length    = 8'(count);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx);
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        case (in_req_type)
          sle_pkg::REQ_INSERT: mem_raddr = AW'(count - CW'(1));
          sle_pkg::REQ_SORT:   mem_raddr = AW'(CW'(1));
          default:             mem_raddr = '0;
        endcase
      end
      S_INS_SH: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx);
        mem_raddr = AW'(idx - CW'(2));
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos - 8'd1);
        mem_wdata = val;
      end
      S_DEL: begin
        mem_we    = differs;
        mem_waddr = AW'(wr);
        mem_raddr = AW'(idx + CW'(1));
      end
      S_LOC: begin
        mem_raddr = AW'(idx + CW'(1));
      end
      S_SORT_T: begin
        mem_raddr = AW'(k - CW'(1));
      end
      S_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(m);
        mem_wdata = greater ? mem_rdata : tval;
        mem_raddr = greater ? AW'(m - CW'(2)) : AW'(k + CW'(1));
      end
      S_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(m);
        mem_wdata = tval;
        mem_raddr = AW'(k + CW'(1));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            val   <= in_value;
            pos   <= in_position;
            found <= 8'd0;
            ok    <= 1'b0;
            idx   <= '0;
            wr    <= '0;
            case (in_req_type)
              sle_pkg::REQ_INSERT: begin
                idx <= count;
                if (!ins_ok) begin
                  state <= S_DONE;
                end else if (ins_append) begin
                  state <= S_INS_PUT;
                end else begin
                  state <= S_INS_SH;
                end
              end
              sle_pkg::REQ_DELETE: begin
                state <= (count == '0) ? S_DONE : S_DEL;
              end
              sle_pkg::REQ_LOCATE: begin
                state <= (count == '0) ? S_DONE : S_LOC;
              end
              default: begin
                ok    <= 1'b1;
                k     <= CW'(1);
                state <= (count < CW'(2)) ? S_DONE : S_SORT_T;
              end
            endcase
          end
        end
        S_INS_SH: begin
          if (PW'(idx) == PW'(pos)) begin
            state <= S_INS_PUT;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          ok    <= 1'b1;
          state <= S_DONE;
        end
        S_DEL: begin
          wr <= wr_next;
          if (more_items) begin
            idx <= idx + CW'(1);
          end else begin
            count <= wr_next;
            ok    <= wr_next != count;
            state <= S_DONE;
          end
        end
        S_LOC: begin
          if (!differs) begin
            found <= 8'(idx + CW'(1));
            ok    <= 1'b1;
            state <= S_DONE;
          end else if (more_items) begin
            idx <= idx + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_SORT_T: begin
          tval  <= mem_rdata;
          m     <= k;
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (greater) begin
            m <= m - CW'(1);
            if (m == CW'(1)) begin
              state <= S_SORT_PUT;
            end
          end else if (more_keys) begin
            k     <= k + CW'(1);
            state <= S_SORT_T;
          end else begin
            state <= S_DONE;
          end
        end
        S_SORT_PUT: begin
          if (more_keys) begin
            k     <= k + CW'(1);
            state <= S_SORT_T;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list count above depth");

  a_wr_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) |-> (wr <= idx))
    else $error("compaction write pointer overtook read pointer");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (state == S_IDLE))
    else $error("sequencer not idle after result");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ($past(rst) || $past(state) == S_INS_PUT || $past(state) == S_DEL))
    else $error("count changed outside insert or delete");
`endif

endmodule

FILE: sim/tb_sequential_list_engine.sv
module tb_sequential_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH  = 128;
  localparam int ITEMS       = 850;    // total request beats, directed part included
  localparam int QUIET_TAIL  = 120;    // last beats run with no idling on either side
  localparam int STALL_LIMIT = 60000;  // cycles with no beat on either channel
  localparam int SETTLE      = 50;     // cycles watched once nothing is outstanding

  // one request beat as the generator plans it
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_beat_t;

  logic clk = 1'b0;
  logic rst;

  sle_req_if req_ch ();
  sle_rsp_if rsp_ch ();

  sequential_list_engine #(
    .DEPTH (LIST_DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the list. Updated in the driver at the edge where a request beat
  // is taken, so after every accepted beat it matches what the block holds.
  // ---------------------------------------------------------------------------
  logic signed [31:0]   model_list[$];
  sle_pkg::sle_result_t expected_results[$];
  req_beat_t            request_q[$];

  req_beat_t            cur_req;       // beat on the request bus
  logic                 bus_loaded;    // cur_req offered but not yet taken
  int unsigned          gap_left;      // sender idle burst
  int unsigned          stall_left;    // receiver idle burst
  logic                 quiet;         // tail of the run: no idling at all
  sle_pkg::sle_result_t want;

  int unsigned gen_count;
  int unsigned n_errors;
  int unsigned n_rsp;
  int unsigned n_kind[4];
  int unsigned n_ins_refused;
  int unsigned n_full_refused;
  int unsigned peak_len;

  // Carries out one request on the shadow list and returns the response the
  // block owes for it.
  function automatic sle_pkg::sle_result_t apply_list_request(req_beat_t r);
    sle_pkg::sle_result_t res;
    logic signed [31:0]   kept[$];
    logic signed [31:0]   key;
    int                   n, k, m;
    n   = model_list.size();
    res = '0;
    case (r.kind)
      sle_pkg::REQ_INSERT: begin
        // position is 1-based; anything past the tail+1 or into a full list is refused
        if (r.position != 8'd0 && int'(r.position) <= n + 1 && n < LIST_DEPTH) begin
          model_list.insert(int'(r.position) - 1, r.value);
          res.ok = 1'b1;
        end
      end
      sle_pkg::REQ_DELETE: begin
        foreach (model_list[i])
          if (model_list[i] != r.value) kept.push_back(model_list[i]);
        res.ok     = (kept.size() != n);
        model_list = kept;
      end
      sle_pkg::REQ_LOCATE: begin
        for (k = 0; k < n && res.ok == 1'b0; k++) begin
          if (model_list[k] == r.value) begin
            res.ok             = 1'b1;
            res.found_position = 8'(k + 1);
          end
        end
      end
      sle_pkg::REQ_SORT: begin
        // stable insertion sort, signed compare
        for (k = 1; k < n; k++) begin
          key = model_list[k];
          m   = k;
          while (m > 0 && model_list[m-1] > key) begin
            model_list[m] = model_list[m-1];
            m--;
          end
          model_list[m] = key;
        end
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.list_length = 8'(model_list.size());
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes planned beats from request_q, holds each on the bus until
  // the block takes it, with random idle bursts in between.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      bus_loaded = 1'b0;
      gap_left   = 0;
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        n_kind[cur_req.kind]++;
        if (cur_req.kind == sle_pkg::REQ_INSERT && model_list.size() == LIST_DEPTH)
          n_full_refused++;
        want = apply_list_request(cur_req);
        if (cur_req.kind == sle_pkg::REQ_INSERT && !want.ok) n_ins_refused++;
        if (model_list.size() > peak_len) peak_len = model_list.size();
        expected_results.push_back(want);
        bus_loaded = 1'b0;
      end
      if (!bus_loaded) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 7);
          end else begin
            cur_req    = request_q.pop_front();
            bus_loaded = 1'b1;
          end
        end
      end
      req_ch.valid    <= bus_loaded;
      req_ch.req_type <= cur_req.kind;
      req_ch.position <= cur_req.position;
      req_ch.value    <= cur_req.value;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure on the response channel; every response beat
  // is checked field by field against the oldest outstanding expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("response beat %0d with nothing outstanding", n_rsp));
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.ok !== want.ok)
            report_mismatch($sformatf("beat %0d ok: got %b, want %b",
                                      n_rsp, rsp_ch.ok, want.ok));
          if (rsp_ch.found_position !== want.found_position)
            report_mismatch($sformatf("beat %0d found_position: got %0d, want %0d",
                                      n_rsp, rsp_ch.found_position, want.found_position));
          if (rsp_ch.list_length !== want.list_length)
            report_mismatch($sformatf("beat %0d list_length: got %0d, want %0d",
                                      n_rsp, rsp_ch.list_length, want.list_length));
        end
        n_rsp++;
      end
      if (stall_left != 0) stall_left--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog: gives up once neither channel has moved a beat for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Hands one beat to the driver once the previous beat has been taken, so
  // only one planned beat is ever pending.
  task automatic queue_request(logic [1:0] kind, logic [7:0] pos, logic signed [31:0] v);
    req_beat_t item;
    do @(negedge clk); while (request_q.size() != 0 || bus_loaded);
    item.kind     = kind;
    item.position = pos;
    item.value    = v;
    request_q.push_back(item);
    gen_count++;
    quiet = (gen_count >= ITEMS - QUIET_TAIL);
  endtask

  // Sender holds off until every outstanding response has come back.
  task automatic drain_all();
    do @(negedge clk);
    while (request_q.size() != 0 || bus_loaded || expected_results.size() != 0);
  endtask

  // Small set of values so deletes and locates keep finding duplicates;
  // the signed extremes are in it on purpose.
  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(0, 7))
      0: return -32'sd2;
      1: return -32'sd1;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return 32'sd2;
      5: return 32'sd7;
      6: return 32'sh7FFF_FFFF;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 40) return pool_value();
    return $urandom;
  endfunction

  // mostly a value that is in the list right now
  function automatic logic signed [31:0] pick_present();
    if (model_list.size() != 0 && $urandom_range(0, 9) < 7)
      return model_list[$urandom_range(0, model_list.size() - 1)];
    return pick_value();
  endfunction

  // insert position: head, tail, middle, or out of range now and then
  function automatic logic [7:0] pick_position(int unsigned len);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      case ($urandom_range(0, 2))
        0: return 8'd0;
        1: return 8'(len + 2);
        default: return 8'($urandom_range(len + 2, 255));
      endcase
    end
    if (roll < 35) return 8'd1;
    if (roll < 55) return 8'(len + 1);
    return 8'($urandom_range(1, len + 1));
  endfunction

  task automatic random_request();
    int unsigned len, roll, ins_w, del_w;
    len = model_list.size();
    // keep lists short most of the time so sorts stay cheap
    ins_w = (len > 24) ? 20 : 45;
    del_w = (len > 24) ? 40 : 15;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w)
      queue_request(sle_pkg::REQ_INSERT, pick_position(len), pick_value());
    else if (roll < ins_w + del_w)
      queue_request(sle_pkg::REQ_DELETE, 8'($urandom), pick_present());
    else if (roll < ins_w + del_w + 20)
      queue_request(sle_pkg::REQ_LOCATE, 8'($urandom), pick_present());
    else
      queue_request(sle_pkg::REQ_SORT, 8'($urandom), $urandom);
  endtask

  // Grows the list to DEPTH, pokes at the full list, sorts it, then deletes
  // values until it is empty again.
  task automatic fill_and_drain();
    while (model_list.size() < LIST_DEPTH)
      queue_request(sle_pkg::REQ_INSERT, 8'($urandom_range(1, model_list.size() + 1)),
                    pick_value());
    queue_request(sle_pkg::REQ_INSERT, 8'(LIST_DEPTH + 1), pick_value());  // in range, but full
    queue_request(sle_pkg::REQ_INSERT, 8'd1, pick_value());                // full again
    queue_request(sle_pkg::REQ_LOCATE, 8'($urandom), model_list[LIST_DEPTH-1]);
    queue_request(sle_pkg::REQ_SORT, 8'($urandom), $urandom);
    queue_request(sle_pkg::REQ_LOCATE, 8'($urandom), model_list[LIST_DEPTH-1]);
    queue_request(sle_pkg::REQ_SORT, 8'($urandom), $urandom);             // already sorted
    while (model_list.size() != 0)
      queue_request(sle_pkg::REQ_DELETE, 8'($urandom),
                    model_list[$urandom_range(0, model_list.size() - 1)]);
    drain_all();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned fills_done;
    // every block input known from time zero
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = sle_pkg::REQ_INSERT;
    req_ch.position = 8'd0;
    req_ch.value    = 32'sd0;
    rsp_ch.ready    = 1'b0;
    cur_req         = '0;
    bus_loaded      = 1'b0;
    quiet           = 1'b0;
    gen_count       = 0;
    n_errors        = 0;
    n_rsp           = 0;
    n_ins_refused   = 0;
    n_full_refused  = 0;
    peak_len        = 0;
    fills_done      = 0;
    foreach (n_kind[i]) n_kind[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, rejected positions, signed extremes, duplicates
    queue_request(sle_pkg::REQ_LOCATE, 8'd0, 32'sd0);          // locate on empty list
    queue_request(sle_pkg::REQ_DELETE, 8'd0, 32'sd0);          // delete on empty list
    queue_request(sle_pkg::REQ_SORT,   8'd0, 32'sd0);          // sort with nothing in it
    queue_request(sle_pkg::REQ_INSERT, 8'd0, 32'sd5);          // position zero
    queue_request(sle_pkg::REQ_INSERT, 8'd2, 32'sd5);          // one past tail+1
    queue_request(sle_pkg::REQ_INSERT, 8'd1, 32'sh7FFF_FFFF);
    queue_request(sle_pkg::REQ_SORT,   8'hFF, 32'sd0);         // single entry
    queue_request(sle_pkg::REQ_INSERT, 8'd1, 32'sh8000_0000);  // at the head
    queue_request(sle_pkg::REQ_INSERT, 8'd3, -32'sd1);         // append
    queue_request(sle_pkg::REQ_INSERT, 8'd2, 32'sd0);          // middle
    queue_request(sle_pkg::REQ_INSERT, 8'hFF, 32'sd9);         // all-ones position
    queue_request(sle_pkg::REQ_INSERT, 8'd6, 32'sd9);          // length+2
    queue_request(sle_pkg::REQ_LOCATE, 8'hAA, 32'sh8000_0000); // found at the head
    queue_request(sle_pkg::REQ_LOCATE, 8'h55, 32'sd5);         // absent
    queue_request(sle_pkg::REQ_INSERT, 8'd5, 32'sh7FFF_FFFF);  // duplicate of max
    queue_request(sle_pkg::REQ_INSERT, 8'd1, 32'sd1);
    queue_request(sle_pkg::REQ_SORT,   8'd0, 32'sd0);
    queue_request(sle_pkg::REQ_LOCATE, 8'd0, 32'sh7FFF_FFFF);  // first of two equal
    queue_request(sle_pkg::REQ_DELETE, 8'd0, 32'sh7FFF_FFFF);  // removes both
    queue_request(sle_pkg::REQ_DELETE, 8'd0, 32'sd12345);      // no match
    queue_request(sle_pkg::REQ_SORT,   8'd0, 32'sd0);          // already in order
    queue_request(sle_pkg::REQ_DELETE, 8'h80, -32'sd1);
    queue_request(sle_pkg::REQ_LOCATE, 8'h7F, 32'sd1);
    drain_all();

    // random part, with two full-list episodes mixed in
    while (gen_count < ITEMS) begin
      if ((gen_count >= 150 && fills_done == 0) || (gen_count >= 450 && fills_done == 1)) begin
        fill_and_drain();
        fills_done++;
      end else begin
        random_request();
      end
    end

    drain_all();
    repeat (SETTLE) @(posedge clk);

    $display("Requests: %0d insert, %0d delete, %0d locate, %0d sort; %0d responses checked",
             n_kind[sle_pkg::REQ_INSERT], n_kind[sle_pkg::REQ_DELETE],
             n_kind[sle_pkg::REQ_LOCATE], n_kind[sle_pkg::REQ_SORT], n_rsp);
    $display("Inserts refused: %0d (%0d into a full list); longest list %0d of %0d",
             n_ins_refused, n_full_refused, peak_len, LIST_DEPTH);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d responses missing", n_errors, expected_results.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
